### rtl/dcpw_pkg.sv
// Shared types and constants for the DAG critical-path workload unit.
// Field widths, tdata layouts and saturation limits; no dependencies.
package dcpw_pkg;

    localparam int WCET_W     = 32;
    localparam int POS_W      = 10;
    localparam int WORK_W     = 48;
    localparam int PATH_W     = 47;
    localparam int MISS_W     = 11;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 160;
    localparam int M_PAD_W    = M_TDATA_W - (WORK_W + PATH_W + WORK_W + MISS_W);

    localparam logic [WORK_W-1:0] WORK_MAX = {1'b0, {(WORK_W-1){1'b1}}};
    localparam logic [WORK_W-1:0] WORK_MIN = {1'b1, {(WORK_W-1){1'b0}}};
    localparam logic [MISS_W-1:0] MISS_MAX = {MISS_W{1'b1}};

    // One accepted item as it sits in the compute stage.
    typedef struct packed {
        logic [WCET_W-1:0] wcet;
        logic              has_pred;
        logic [POS_W-1:0]  pos;
        logic              last_pred;
        logic              last_node;
    } dcpw_item_t;

endpackage

### rtl/dag_critical_path_workload_top.sv
// Top level of the DAG critical-path workload unit: workload store, compute stage,
// output register. Depends on dcpw_pkg and dcpw_ram.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+------------------------------------------
//  s_      | in  | s_tvalid / s_tready | s_tdata, s_tlast = last_pred, s_tuser = last_node
//  m_      | out | m_tvalid / m_tready | m_tdata, m_tlast = graph_done
//
// Flow: one item per cycle while no stall holds s_tready low. The store read is
// issued on the same edge that loads the item into the compute stage, so a node's
// result passes from the compute stage register into the output register; the store
// write of one node is forwarded to a read of the same entry issued in that cycle.
// Reset: clears counters, totals and the pending maximum; the store is not cleared.
// Stalls: s_tready drops while a node's final item waits on a full output register.
module dag_critical_path_workload_top #(
    parameter int MAX_NODES = 1024
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [31:0] node_wcet, [32] has_pred, [42:33] pred_position, [47:43] zero
    input  logic [dcpw_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             s_tlast,
    // [0] last_node
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [47:0] node_workload, [94:48] path_length, [142:95] total_volume,
    // [153:143] missing_time_count, [159:154] zero
    output logic [dcpw_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tlast
);
    import dcpw_pkg::*;

    localparam int ADDR_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Handshake
    logic s_acc;
    logic stall;
    logic st1_go;

    // Compute stage
    logic       st1_valid_reg, st1_valid_next;
    dcpw_item_t st1_reg, st1_next;
    logic              fwd_hit_reg, fwd_hit_next;
    logic [WORK_W-1:0] fwd_data_reg, fwd_data_next;

    // Running state
    logic [PATH_W-1:0] pend_reg, pend_next;
    logic [CNT_W-1:0]  node_cnt_reg, node_cnt_next;
    logic [PATH_W-1:0] long_reg, long_next;
    logic [WORK_W-1:0] vol_reg, vol_next;
    logic [MISS_W-1:0] miss_reg, miss_next;

    // Output register
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                 m_tlast_reg, m_tlast_next;

    // Store ports
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORK_W-1:0] work;
    logic [ADDR_W-1:0] rd_addr;
    logic [WORK_W-1:0] rd_data;

    // Datapath
    logic [WORK_W-1:0] p_val;
    logic              rd_ok;
    logic              p_up;
    logic [PATH_W-1:0] pend_eff;
    logic [WORK_W:0]   work_sum;
    logic [WORK_W:0]   vol_sum;
    logic [WORK_W-1:0] vol_sat;
    logic [PATH_W-1:0] long_upd;
    logic [MISS_W-1:0] miss_upd;
    logic              wcet_missing;
    logic              store_ok;

    // Hold the compute stage only when it finishes a node and the result slot is busy.
    assign stall    = st1_valid_reg && st1_reg.last_pred && m_tvalid_reg && !m_tready;
    assign st1_go   = st1_valid_reg && !stall;
    assign s_tready = !stall;
    assign s_acc    = s_tvalid && s_tready;

    // Issue the store read as the item is taken; the read data stays put during a stall.
    assign rd_addr = ADDR_W'(s_tdata[42:33]);

    dcpw_ram #(
        .DATA_W (WORK_W),
        .DEPTH  (MAX_NODES)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (work),
        .rd_en   (s_acc),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        st1_next.wcet      = s_tdata[31:0];
        st1_next.has_pred  = s_tdata[32];
        st1_next.pos       = s_tdata[42:33];
        st1_next.last_pred = s_tlast;
        st1_next.last_node = s_tuser;
        // Forward the node being written this cycle to a read of the same entry.
        fwd_hit_next  = wr_en && (wr_addr == rd_addr);
        fwd_data_next = work;
    end

    always_comb begin
        p_val    = fwd_hit_reg ? fwd_data_reg : rd_data;
        // Positions not earlier than the current node count as zero.
        rd_ok    = st1_reg.has_pred && (CMP_W'(st1_reg.pos) < CMP_W'(node_cnt_reg));
        p_up     = rd_ok && !p_val[WORK_W-1] && (p_val[PATH_W-1:0] > pend_reg);
        pend_eff = p_up ? p_val[PATH_W-1:0] : pend_reg;

        // Pending max is never negative, so only the upper bound can be hit.
        work_sum = {2'b00, pend_eff} + {{(WORK_W+1-WCET_W){st1_reg.wcet[WCET_W-1]}},
                                       st1_reg.wcet};
        work     = (!work_sum[WORK_W] && work_sum[WORK_W-1]) ? WORK_MAX
                                                             : work_sum[WORK_W-1:0];

        vol_sum  = {vol_reg[WORK_W-1], vol_reg}
                 + {{(WORK_W+1-WCET_W){st1_reg.wcet[WCET_W-1]}}, st1_reg.wcet};
        if (vol_sum[WORK_W] != vol_sum[WORK_W-1]) begin
            vol_sat = vol_sum[WORK_W] ? WORK_MIN : WORK_MAX;
        end else begin
            vol_sat = vol_sum[WORK_W-1:0];
        end

        long_upd = (!work[WORK_W-1] && (work[PATH_W-1:0] > long_reg)) ? work[PATH_W-1:0]
                                                                       : long_reg;

        wcet_missing = st1_reg.wcet[WCET_W-1] || (st1_reg.wcet == '0);
        miss_upd     = (wcet_missing && (miss_reg != MISS_MAX)) ? miss_reg + MISS_W'(1)
                                                                : miss_reg;

        store_ok = node_cnt_reg < CNT_W'(MAX_NODES);
        wr_en    = st1_go && st1_reg.last_pred && store_ok;
        wr_addr  = node_cnt_reg[ADDR_W-1:0];
    end

    always_comb begin
        st1_valid_next = s_acc ? 1'b1 : (st1_go ? 1'b0 : st1_valid_reg);

        pend_next     = pend_reg;
        node_cnt_next = node_cnt_reg;
        long_next     = long_reg;
        vol_next      = vol_reg;
        miss_next     = miss_reg;

        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;

        if (st1_go) begin
            pend_next = pend_eff;
            if (st1_reg.last_pred) begin
                pend_next     = '0;
                m_tvalid_next = 1'b1;
                m_tdata_next  = {{M_PAD_W{1'b0}}, miss_upd, vol_sat, long_upd, work};
                m_tlast_next  = st1_reg.last_node;
                // Restart all totals after the graph's last node.
                if (st1_reg.last_node) begin
                    node_cnt_next = '0;
                    long_next     = '0;
                    vol_next      = '0;
                    miss_next     = '0;
                end else begin
                    node_cnt_next = store_ok ? node_cnt_reg + CNT_W'(1) : node_cnt_reg;
                    long_next     = long_upd;
                    vol_next      = vol_sat;
                    miss_next     = miss_upd;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            pend_reg      <= '0;
            node_cnt_reg  <= '0;
            long_reg      <= '0;
            vol_reg       <= '0;
            miss_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            st1_valid_reg <= st1_valid_next;
            pend_reg      <= pend_next;
            node_cnt_reg  <= node_cnt_next;
            long_reg      <= long_next;
            vol_reg       <= vol_next;
            miss_reg      <= miss_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // Payload registers: load on accept or on result.
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            st1_reg      <= st1_next;
            fwd_hit_reg  <= fwd_hit_next;
            fwd_data_reg <= fwd_data_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

### rtl/dcpw_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// Read returns the old contents on a same-address write; no dependencies.
module dcpw_ram #(
    parameter int DATA_W = 48,
    parameter int DEPTH  = 1024
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  logic [DATA_W-1:0]         wr_data,
    input  logic                      rd_en,
    input  logic [$clog2(DEPTH)-1:0]  rd_addr,
    output logic [DATA_W-1:0]         rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for dag_critical_path_workload_top: a directed stimulus table and random
// task graphs, with results checked against an in-bench workload predictor. Depends on dcpw_pkg.
module tb_top;
    import dcpw_pkg::*;

    localparam int NODE_CAP  = 256;    // small store so one graph can overrun it
    localparam int STIM_ROWS = 16;
    localparam int RAND_ITEMS = 340;
    localparam int LONG_GRAPH = 280;   // a few dozen nodes past the store's capacity
    localparam int HOLD_CYCLES = 400;

    // One result as it travels on m_tdata / m_tlast.
    typedef struct packed {
        logic [WORK_W-1:0] workload;
        logic [PATH_W-1:0] path;
        logic [WORK_W-1:0] volume;
        logic [MISS_W-1:0] missing;
        logic              done;
    } node_result_t;

    // One row of the directed stimulus: the item, and a typed-in result where it is obvious.
    typedef struct packed {
        dcpw_item_t   it;
        logic         typed;
        node_result_t want;
    } stim_row_t;

    localparam node_result_t NO_RES = '0;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tlast;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    dag_critical_path_workload_top #(
        .MAX_NODES (NODE_CAP)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the workload store and the
    // per-graph running totals.
    // ------------------------------------------------------------------
    longint       workload_mem [NODE_CAP];
    longint       pred_max    = 0;
    longint       longest_wl  = 0;
    longint       volume_acc  = 0;
    int           node_pos    = 0;
    int           missing_cnt = 0;

    node_result_t node_results_q [$];
    int           error_count = 0;
    int           items_in    = 0;
    bit           tx_quiet    = 1'b0;
    bit           rx_quiet    = 1'b0;
    bit           hold_rx     = 1'b0;

    // Directed stimulus. Rows 0, 1 and 11 carry their result typed in; the others
    // go through the predictor.
    stim_row_t stim_tab [STIM_ROWS] = '{
        // largest execution time, first node of the graph
        '{'{32'h7FFF_FFFF, 1'b0, 10'd0, 1'b1, 1'b0}, 1'b1,
          '{48'd2147483647, 47'd2147483647, 48'd2147483647, 11'd0, 1'b0}},
        // most negative execution time: counts as missing, workload below zero
        '{'{32'h8000_0000, 1'b0, 10'd0, 1'b1, 1'b0}, 1'b1,
          '{48'hFFFF_8000_0000, 47'd2147483647, 48'hFFFF_FFFF_FFFF, 11'd1, 1'b0}},
        // intermediate items: junk time and last_node must be ignored
        '{'{32'hDEAD_BEEF, 1'b1, 10'd0, 1'b0, 1'b1}, 1'b0, NO_RES},
        '{'{32'h0000_0000, 1'b1, 10'd1, 1'b0, 1'b0}, 1'b0, NO_RES},
        // final item pointing at a position not yet reached
        '{'{32'd10,        1'b1, 10'd5, 1'b1, 1'b0}, 1'b0, NO_RES},
        // zero execution time, highest position value
        '{'{32'h0000_0000, 1'b1, 10'd1023, 1'b1, 1'b0}, 1'b0, NO_RES},
        '{'{32'd1,         1'b1, 10'd2, 1'b1, 1'b0}, 1'b0, NO_RES},
        // single item without a predecessor; the position is don't-care
        '{'{32'hFFFF_FFFF, 1'b0, 10'd3, 1'b1, 1'b0}, 1'b0, NO_RES},
        '{'{32'd55,        1'b1, 10'd4, 1'b0, 1'b0}, 1'b0, NO_RES},
        '{'{32'h0000_0000, 1'b0, 10'd3, 1'b0, 1'b0}, 1'b0, NO_RES},
        // close the graph
        '{'{32'd5,         1'b1, 10'd3, 1'b1, 1'b1}, 1'b0, NO_RES},
        // one-node graph right after a graph end
        '{'{32'd7,         1'b1, 10'd0, 1'b1, 1'b1}, 1'b1,
          '{48'd7, 47'd7, 48'd7, 11'd0, 1'b1}},
        '{'{32'd3,         1'b0, 10'd0, 1'b1, 1'b0}, 1'b0, NO_RES},
        '{'{32'h0000_0000, 1'b1, 10'd0, 1'b0, 1'b0}, 1'b0, NO_RES},
        // final item with no predecessor after a predecessor item: keeps the pending max
        '{'{32'd4,         1'b0, 10'd0, 1'b1, 1'b0}, 1'b0, NO_RES},
        '{'{32'hFFFF_FFFB, 1'b1, 10'd1, 1'b1, 1'b1}, 1'b0, NO_RES}
    };

    // Clamp to the signed 48-bit range.
    function automatic longint clamp48(input longint v);
        longint hi;
        longint lo;
        hi = longint'($signed(WORK_MAX));
        lo = longint'($signed(WORK_MIN));
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Advance the predictor by one accepted item; return 1 when the item
    // completes a node, with the node's result in res.
    function automatic bit accumulate_workload(input dcpw_item_t it, output node_result_t res);
        longint wcet_v;
        longint work;
        wcet_v = longint'($signed(it.wcet));
        res    = '0;
        // only positions already written in this graph contribute
        if (it.has_pred && int'(it.pos) < node_pos && int'(it.pos) < NODE_CAP) begin
            if (workload_mem[it.pos] > pred_max) pred_max = workload_mem[it.pos];
        end
        if (!it.last_pred) return 1'b0;

        work = clamp48(pred_max + wcet_v);
        // a full store keeps its contents; the node still gets a result
        if (node_pos < NODE_CAP) begin
            workload_mem[node_pos] = work;
            node_pos++;
        end
        if (work > longest_wl) longest_wl = work;
        volume_acc = clamp48(volume_acc + wcet_v);
        if (wcet_v <= 0 && missing_cnt < int'(MISS_MAX)) missing_cnt++;
        pred_max = 0;

        res.workload = work[WORK_W-1:0];
        res.path     = longest_wl[PATH_W-1:0];
        res.volume   = volume_acc[WORK_W-1:0];
        res.missing  = missing_cnt[MISS_W-1:0];
        res.done     = it.last_node;

        // restart the totals after the last node of a graph
        if (it.last_node) begin
            node_pos    = 0;
            longest_wl  = 0;
            volume_acc  = 0;
            missing_cnt = 0;
        end
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] expected_v);
        error_count++;
        $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, expected_v);
    endtask

    // Idle gap before the next item: none during a quiet stretch, else drawn at random.
    function automatic int idle_draw(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 3);
    endfunction

    // Execution time: extremes, zero, negatives and ordinary positive values.
    function automatic logic [31:0] pick_wcet();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'd0 - $urandom_range(1, 5000);
            4:       return $urandom;
            default: return $urandom_range(1, 100000);
        endcase
    endfunction

    // Predecessor position for node idx: mostly an earlier node, biased to
    // recent ones, sometimes any position at all.
    function automatic logic [9:0] pick_pos(input int idx);
        int reach;
        reach = (idx > NODE_CAP) ? NODE_CAP : idx;
        if (reach == 0 || $urandom_range(0, 7) == 0) return 10'($urandom_range(0, 1023));
        if ($urandom_range(0, 1) == 0)
            return 10'($urandom_range(reach - 1, (reach > 8) ? reach - 8 : 0));
        return 10'($urandom_range(reach - 1, 0));
    endfunction

    // Offer one item and hold it until accepted; then run the predictor.
    // A typed-in result, where given, replaces the predicted one.
    task automatic send_item(input dcpw_item_t it, input logic typed, input node_result_t want);
        node_result_t res;
        int           gap;
        if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
        gap = idle_draw(tx_quiet);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, it.pos, it.has_pred, it.wcet};
        s_tlast  <= it.last_pred;
        s_tuser  <= it.last_node;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_in++;
        if (accumulate_workload(it, res)) node_results_q.push_back(typed ? want : res);
    endtask

    // Send one node: one item per predecessor, or a single item without one.
    // Intermediate items carry junk time and last_node, and now and then no
    // predecessor at all.
    task automatic send_node(input int idx, input logic [31:0] wcet, input bit last_node,
                             input int pred_limit);
        dcpw_item_t it;
        int         n_pred;
        int         n_items;
        n_pred  = $urandom_range(0, pred_limit);
        n_items = (n_pred == 0) ? 1 : n_pred;
        for (int k = 0; k < n_items; k++) begin
            it.last_pred = (k == n_items - 1);
            it.has_pred  = (n_pred > 0);
            if (!it.last_pred && $urandom_range(0, 7) == 0) it.has_pred = 1'b0;
            it.pos       = it.has_pred ? pick_pos(idx) : 10'($urandom_range(0, 1023));
            it.wcet      = it.last_pred ? wcet : $urandom;
            it.last_node = it.last_pred ? last_node : 1'($urandom_range(0, 1));
            send_item(it, 1'b0, NO_RES);
        end
    endtask

    // Drop valid and wait until every expected result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (node_results_q.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Stimulus: reset, directed table, random graphs, one long graph.
    // ------------------------------------------------------------------
    initial begin
        int          n_nodes;
        int          rand_start;
        bit          held;
        bit          paused;
        logic [31:0] w;
        held   = 1'b0;
        paused = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        s_tuser  <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // walk the directed table
        foreach (stim_tab[r]) send_item(stim_tab[r].it, stim_tab[r].typed, stim_tab[r].want);
        drain_results();

        // random graphs: mostly short, sometimes a few dozen to under a hundred nodes
        rand_start = items_in;
        while (items_in < rand_start + RAND_ITEMS) begin
            n_nodes = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 90)
                                                   : $urandom_range(1, 40);
            for (int j = 0; j < n_nodes; j++) send_node(j, pick_wcet(), j == n_nodes - 1, 3);
            // stall the result side for a long stretch while items keep coming
            if (!held && items_in > rand_start + 100) begin
                hold_rx = 1'b1;
                held    = 1'b1;
            end
            // pause the input side until the block has emptied out
            if (!paused && items_in > rand_start + 200) begin
                paused = 1'b1;
                drain_results();
            end
        end

        // one graph longer than the store: fills it, then keeps going with
        // mostly non-positive times past the store's end
        for (int j = 0; j < LONG_GRAPH; j++) begin
            if (j < 20) w = $urandom_range(1, 1000000);
            else if ($urandom_range(0, 3) == 0) w = 32'h0000_0000;
            else if ($urandom_range(0, 15) == 0) w = 32'h8000_0000;
            else w = 32'd0 - $urandom_range(1, 5000);
            send_node(j, w, j == LONG_GRAPH - 1, 1);
        end

        drain_results();
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random backpressure, quiet stretches, and one long hold
    // requested by the stimulus.
    // ------------------------------------------------------------------
    initial begin
        int gap;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
            gap = idle_draw(rx_quiet);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            if (hold_rx) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_rx = 1'b0;
            end
        end
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge aclk) begin : result_check
        node_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (node_results_q.size() == 0) begin
                flag_mismatch("result with none expected", 64'(m_tdata[47:0]), 64'd0);
            end else begin
                want = node_results_q.pop_front();
                if (m_tdata[47:0] !== want.workload)
                    flag_mismatch("node_workload", 64'(m_tdata[47:0]), 64'(want.workload));
                if (m_tdata[94:48] !== want.path)
                    flag_mismatch("path_length", 64'(m_tdata[94:48]), 64'(want.path));
                if (m_tdata[142:95] !== want.volume)
                    flag_mismatch("total_volume", 64'(m_tdata[142:95]), 64'(want.volume));
                if (m_tdata[153:143] !== want.missing)
                    flag_mismatch("missing_time_count", 64'(m_tdata[153:143]),
                                  64'(want.missing));
                if (m_tlast !== want.done)
                    flag_mismatch("graph_done", 64'(m_tlast), 64'(want.done));
            end
        end
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("%0t: watchdog expired, %0d results still expected", $time,
                 node_results_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
